/* sv/hss_pkg.sv */
// Shared types, widths and constants for the half-step stepper sequencer.
// No dependencies; used by every module of the block.
package hss_pkg;

    // Fixed point layout of every delay value
    localparam int DELAY_INT_BITS  = 13;
    localparam int DELAY_FRAC_BITS = 8;
    localparam int DW              = DELAY_INT_BITS + DELAY_FRAC_BITS;

    // Speed change operands
    localparam int FRAC_W   = 8;                    // Q0.8 change fraction
    localparam int OFF_W    = 16;                   // change offset width
    localparam int FACTOR_W = FRAC_W + 1;           // 256 +/- fraction
    localparam int PROD_W   = DW + FACTOR_W;
    localparam int SUM_W    = ((DW > OFF_W) ? DW : OFF_W) + 2;

    // Configuration port
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_FLOOR     = 3'd0,
        REG_DELAY_CEIL      = 3'd1,
        REG_START_DELAY     = 3'd2,
        REG_CHANGE_FRACTION = 3'd3,
        REG_CHANGE_OFFSET   = 3'd4
    } cfg_reg_t;

    // Reset values of the registers
    localparam logic [DW-1:0]     RST_DELAY_FLOOR = DW'(8448);
    localparam logic [DW-1:0]     RST_DELAY_CEIL  = DW'(1280000);
    localparam logic [DW-1:0]     RST_START_DELAY = DW'(128000);
    localparam logic [FRAC_W-1:0] RST_FRACTION    = FRAC_W'(51);
    localparam logic [OFF_W-1:0]  RST_OFFSET      = OFF_W'(51);

    localparam logic [DELAY_INT_BITS-1:0] TICK_MAX = '1;

    // Speed settings seen by the delay unit
    typedef struct packed {
        logic [DW-1:0]     delay_floor;
        logic [DW-1:0]     delay_ceil;
        logic [FRAC_W-1:0] change_fraction;
        logic [OFF_W-1:0]  change_offset;
    } speed_cfg_t;

    // Step decision of one tick
    typedef struct packed {
        logic [2:0]                phase;
        logic [DELAY_INT_BITS-1:0] tick_count;
        logic                      stepped;
    } step_t;

    // Half-step coil table
    function automatic logic [3:0] coil_lookup(input logic [2:0] ph);
        logic [3:0] pat;
        unique case (ph)
            3'd0: pat = 4'b1001;
            3'd1: pat = 4'b0001;
            3'd2: pat = 4'b0011;
            3'd3: pat = 4'b0010;
            3'd4: pat = 4'b0110;
            3'd5: pat = 4'b0100;
            3'd6: pat = 4'b1100;
            3'd7: pat = 4'b1000;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

/* sv/hss_phase_gen.sv */
// Step decision: tick counter compare against the step delay, phase move.
// Depends on hss_pkg.
module hss_phase_gen (
    input  logic [hss_pkg::DELAY_INT_BITS-1:0] tick_count,
    input  logic [hss_pkg::DW-1:0]             step_delay,
    input  logic [2:0]                         phase,
    input  logic                               rotation,
    output hss_pkg::step_t                     step
);

    logic [hss_pkg::DW-1:0] tick_scaled;

    // Compare counter, in delay units, with the delay
    assign tick_scaled = {tick_count, {hss_pkg::DELAY_FRAC_BITS{1'b0}}};

    // Advance phase or count up with saturation
    always_comb
    begin
        step.stepped    = 1'b0;
        step.phase      = phase;
        step.tick_count = tick_count;
        if (tick_scaled >= step_delay)
        begin
            step.stepped    = 1'b1;
            step.tick_count = '0;
            step.phase      = rotation ? (phase - 3'd1) : (phase + 3'd1);
        end
        else if (tick_count < hss_pkg::TICK_MAX)
        begin
            step.tick_count = tick_count + 1'b1;
        end
    end

endmodule

/* sv/hss_delay_unit.sv */
// Speed change: scale the delay by (1-f) or (1+f), apply offset, clamp.
// Depends on hss_pkg. One multiplier, shared by both directions of change.
module hss_delay_unit (
    input  logic [hss_pkg::DW-1:0] delay_in,
    input  logic                   slower,
    input  hss_pkg::speed_cfg_t    cfg,
    output logic [hss_pkg::DW-1:0] delay_out
);

    logic [hss_pkg::FACTOR_W-1:0] factor;
    logic [hss_pkg::PROD_W-1:0]   prod;
    logic [hss_pkg::DW:0]         scaled;
    logic [hss_pkg::SUM_W-1:0]    scaled_ext;
    logic [hss_pkg::SUM_W-1:0]    off_ext;
    logic [hss_pkg::SUM_W-1:0]    fast_sub;
    logic [hss_pkg::SUM_W-1:0]    slow_sum;
    logic [hss_pkg::DW-1:0]       fast_d;
    logic [hss_pkg::DW-1:0]       slow_d;

    // Scale factor 256 - f or 256 + f
    assign factor = slower
        ? (hss_pkg::FACTOR_W'(1 << hss_pkg::FRAC_W) + hss_pkg::FACTOR_W'(cfg.change_fraction))
        : (hss_pkg::FACTOR_W'(1 << hss_pkg::FRAC_W) - hss_pkg::FACTOR_W'(cfg.change_fraction));

    assign prod       = hss_pkg::PROD_W'(delay_in) * hss_pkg::PROD_W'(factor);
    assign scaled     = prod[hss_pkg::PROD_W-1:hss_pkg::FRAC_W];
    assign scaled_ext = hss_pkg::SUM_W'(scaled);
    assign off_ext    = hss_pkg::SUM_W'(cfg.change_offset);

    // Faster: drop offset, floor at zero, clamp to min
    always_comb
    begin
        fast_sub = (scaled_ext <= off_ext) ? '0 : (scaled_ext - off_ext);
        if (fast_sub < hss_pkg::SUM_W'(cfg.delay_floor))
            fast_d = cfg.delay_floor;
        else
            fast_d = fast_sub[hss_pkg::DW-1:0];
    end

    // Slower: add offset, saturate to delay width, clamp to max
    always_comb
    begin
        slow_sum = scaled_ext + off_ext;
        if (slow_sum > hss_pkg::SUM_W'({hss_pkg::DW{1'b1}}))
            slow_d = '1;
        else
            slow_d = slow_sum[hss_pkg::DW-1:0];
        if (slow_d > cfg.delay_ceil)
            slow_d = cfg.delay_ceil;
    end

    assign delay_out = slower ? slow_d : fast_d;

endmodule

/* sv/half_step_stepper_sequencer.sv */
// Top level of the half-step stepper sequencer: channels, state, config.
// Depends on hss_pkg, hss_phase_gen and hss_delay_unit.
//
// Usage: each input word is one loop tick with four button levels
// (cw_button, ccw_button, faster_button, slower_button), taken at a
// clock edge where in_valid is high and in_stall is low. Each tick gives
// exactly one output word (coil_pattern, phase_index, direction,
// step_taken), taken where out_valid is high and out_stall is low.
// Timing: the word waits in the input register until the output can take
// a result, is processed there and its result is registered in the output
// register. Throughput: one tick per cycle while out_stall is low. A tick
// with rising edges on both the faster and slower buttons takes a second
// pass, since the shared delay multiplier runs once for each change.
// Stall: while a result waits under out_stall the input register holds
// its word and in_stall rises once that register is full.
// Reset: phase 0, clockwise, counter 0, delay at the start value, all
// buttons treated as pressed, registers at their defaults.
// Configuration (cfg_wr_en, cfg_index, cfg_data) is written while idle by the user; the block does not enforce it.
module half_step_stepper_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    // Tick input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cw_button,
    input  logic                          ccw_button,
    input  logic                          faster_button,
    input  logic                          slower_button,
    // Result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    coil_pattern,
    output logic [2:0]                    phase_index,
    output logic                          direction,
    output logic                          step_taken,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hss_pkg::DW-1:0]        cfg_data
);

    // Configuration registers
    hss_pkg::speed_cfg_t cfg_reg;

    // Input register
    logic       in_vld_reg;
    logic [3:0] btn_reg;

    // Sequencer state
    logic [2:0]                         phase_reg;
    logic                               rotation_reg;
    logic [hss_pkg::DELAY_INT_BITS-1:0] tick_reg;
    logic [hss_pkg::DW-1:0]             delay_reg;
    logic [3:0]                         last_reg;
    logic                               pend_reg;

    // Output register
    logic       out_vld_reg;
    logic [3:0] coil_reg;
    logic [2:0] phase_out_reg;
    logic       dir_out_reg;
    logic       step_out_reg;

    logic                   can_emit;
    logic                   proc;
    logic                   first;
    logic                   finish;
    logic                   both_edges;
    logic [3:0]             rise;
    logic                   rotation_next;
    logic                   delay_upd;
    logic                   slower_sel;
    logic [hss_pkg::DW-1:0] delay_next;
    hss_pkg::step_t         step;

    // Handshake control
    assign can_emit   = !out_vld_reg || !out_stall;
    assign proc       = in_vld_reg && can_emit;
    assign first      = proc && !pend_reg;
    assign rise       = btn_reg & ~last_reg;
    assign both_edges = first && rise[2] && rise[3];
    assign finish     = proc && (pend_reg || !both_edges);
    assign in_stall   = in_vld_reg && !finish;

    // Step decision
    hss_phase_gen u_phase (
        .tick_count (tick_reg),
        .step_delay (delay_reg),
        .phase      (phase_reg),
        .rotation   (rotation_reg),
        .step       (step)
    );

    // Direction: anticlockwise wins when both rise
    always_comb
    begin
        rotation_next = rotation_reg;
        if (rise[0])
            rotation_next = 1'b0;
        if (rise[1])
            rotation_next = 1'b1;
    end

    // Speed change: faster first, slower in the second pass when both rise
    assign slower_sel = pend_reg || !rise[2];
    assign delay_upd  = (first && (rise[2] || rise[3])) || (proc && pend_reg);

    hss_delay_unit u_delay (
        .delay_in  (delay_reg),
        .slower    (slower_sel),
        .cfg       (cfg_reg),
        .delay_out (delay_next)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_floor     <= hss_pkg::RST_DELAY_FLOOR;
            cfg_reg.delay_ceil      <= hss_pkg::RST_DELAY_CEIL;
            cfg_reg.change_fraction <= hss_pkg::RST_FRACTION;
            cfg_reg.change_offset   <= hss_pkg::RST_OFFSET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hss_pkg::REG_DELAY_FLOOR:     cfg_reg.delay_floor <= cfg_data;
                hss_pkg::REG_DELAY_CEIL:      cfg_reg.delay_ceil <= cfg_data;
                hss_pkg::REG_CHANGE_FRACTION:
                    cfg_reg.change_fraction <= cfg_data[hss_pkg::FRAC_W-1:0];
                hss_pkg::REG_CHANGE_OFFSET:
                    cfg_reg.change_offset <= cfg_data[hss_pkg::OFF_W-1:0];
                // start delay only matters at reset, which restores it
                default: ;
            endcase
        end
    end

    // Hold or load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_vld_reg <= 1'b1;
        else if (finish)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            btn_reg <= {slower_button, faster_button, ccw_button, cw_button};
    end

    // Advance sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            rotation_reg <= 1'b0;
            tick_reg     <= '0;
            last_reg     <= '1;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (first)
            begin
                phase_reg    <= step.phase;
                tick_reg     <= step.tick_count;
                rotation_reg <= rotation_next;
                last_reg     <= btn_reg;
            end
            if (both_edges)
                pend_reg <= 1'b1;
            else if (proc)
                pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= hss_pkg::RST_START_DELAY;
        else if (delay_upd)
            delay_reg <= delay_next;
    end

    // Output register: payload loads on the first pass of a tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= finish || (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (first)
        begin
            coil_reg      <= hss_pkg::coil_lookup(step.phase);
            phase_out_reg <= step.phase;
            dir_out_reg   <= rotation_next;
            step_out_reg  <= step.stepped;
        end
    end

    assign out_valid    = out_vld_reg;
    assign coil_pattern = coil_reg;
    assign phase_index  = phase_out_reg;
    assign direction    = dir_out_reg;
    assign step_taken   = step_out_reg;

endmodule

/* sim/testbench.sv */
// Testbench for half_step_stepper_sequencer: drives button tick words and
// register writes, predicts every result word and checks it field by field.
// Depends on hss_pkg and the RTL of the block.
module testbench;

    localparam int HOLD_CYCLES = 300;
    localparam int SLOW_TICKS  = 40;
    localparam int DELAY_TOP   = (1 << hss_pkg::DW) - 1;

    // Half-step coil drive, entry 0 in the low nibble
    localparam logic [31:0] COIL_SEQ = {4'b1000, 4'b1100, 4'b0100, 4'b0110,
                                        4'b0010, 4'b0011, 4'b0001, 4'b1001};

    // Register values after reset
    localparam logic [hss_pkg::DW-1:0]     DEF_FLOOR = hss_pkg::DW'(8448);
    localparam logic [hss_pkg::DW-1:0]     DEF_CEIL  = hss_pkg::DW'(1280000);
    localparam logic [hss_pkg::DW-1:0]     DEF_START = hss_pkg::DW'(128000);
    localparam logic [hss_pkg::FRAC_W-1:0] DEF_FRAC  = hss_pkg::FRAC_W'(51);
    localparam logic [hss_pkg::OFF_W-1:0]  DEF_OFF   = hss_pkg::OFF_W'(51);

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic cw;
        logic ccw;
        logic faster;
        logic slower;
    } button_word_t;

    typedef struct packed {
        logic [3:0] coil;
        logic [2:0] phase;
        logic       dir;
        logic       stepped;
    } motor_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cw_button = 1'b0;
    logic ccw_button = 1'b0;
    logic faster_button = 1'b0;
    logic slower_button = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] coil_pattern;
    logic [2:0] phase_index;
    logic direction;
    logic step_taken;
    logic cfg_wr_en = 1'b0;
    logic [hss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hss_pkg::DW-1:0] cfg_data = '0;

    button_word_t  pending_ticks[$];
    motor_result_t expected_results[$];
    button_word_t  held_levels = '1;
    logic tick_taken = 1'b0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatch_count = 0;

    // Predicted motor state and register copy
    logic [2:0]                         model_phase;
    logic                               model_ccw;
    logic [hss_pkg::DELAY_INT_BITS-1:0] model_ticks;
    logic [hss_pkg::DW-1:0]             model_delay;
    button_word_t                       model_last;
    logic [hss_pkg::DW-1:0]             set_floor;
    logic [hss_pkg::DW-1:0]             set_ceil;
    logic [hss_pkg::DW-1:0]             set_start;
    logic [hss_pkg::FRAC_W-1:0]         set_frac;
    logic [hss_pkg::OFF_W-1:0]          set_off;

    half_step_stepper_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cw_button     (cw_button),
        .ccw_button    (ccw_button),
        .faster_button (faster_button),
        .slower_button (slower_button),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coil_pattern  (coil_pattern),
        .phase_index   (phase_index),
        .direction     (direction),
        .step_taken    (step_taken),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void reset_motor_model();
        set_floor   = DEF_FLOOR;
        set_ceil    = DEF_CEIL;
        set_start   = DEF_START;
        set_frac    = DEF_FRAC;
        set_off     = DEF_OFF;
        model_phase = '0;
        model_ccw   = 1'b0;
        model_ticks = '0;
        model_delay = set_start;
        model_last  = '1;
    endfunction

    function automatic void apply_setting(input logic [hss_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [hss_pkg::DW-1:0] value);
        case (idx)
            hss_pkg::REG_DELAY_FLOOR:     set_floor = value;
            hss_pkg::REG_DELAY_CEIL:      set_ceil = value;
            hss_pkg::REG_START_DELAY:     set_start = value;
            hss_pkg::REG_CHANGE_FRACTION: set_frac = value[hss_pkg::FRAC_W-1:0];
            hss_pkg::REG_CHANGE_OFFSET:   set_off = value[hss_pkg::OFF_W-1:0];
            default: ;
        endcase
    endfunction

    // One loop tick: step decision on the old rotation, then button edges
    function automatic motor_result_t advance_motor(input button_word_t lv);
        motor_result_t r;
        button_word_t  rise;
        logic [63:0]   d;
        r.stepped = 1'b0;
        if ({model_ticks, {hss_pkg::DELAY_FRAC_BITS{1'b0}}} >= model_delay)
        begin
            model_phase = model_ccw ? model_phase - 3'd1 : model_phase + 3'd1;
            model_ticks = '0;
            r.stepped   = 1'b1;
        end
        else if (~&model_ticks)
        begin
            model_ticks = model_ticks + 1'b1;
        end
        rise = button_word_t'(lv & ~model_last);
        model_last = lv;
        // anticlockwise wins when both direction edges come together
        if (rise.cw)
            model_ccw = 1'b0;
        if (rise.ccw)
            model_ccw = 1'b1;
        // shorten: scale down, drop the offset, clamp to the floor
        if (rise.faster)
        begin
            d = (64'(model_delay) * (64'd256 - 64'(set_frac))) >> 8;
            d = (d <= 64'(set_off)) ? 64'd0 : d - 64'(set_off);
            if (d < 64'(set_floor))
                d = 64'(set_floor);
            model_delay = d[hss_pkg::DW-1:0];
        end
        // lengthen: scale up, add the offset, saturate, clamp to the ceiling
        if (rise.slower)
        begin
            d = ((64'(model_delay) * (64'd256 + 64'(set_frac))) >> 8) + 64'(set_off);
            if (d > 64'(DELAY_TOP))
                d = 64'(DELAY_TOP);
            if (d > 64'(set_ceil))
                d = 64'(set_ceil);
            model_delay = d[hss_pkg::DW-1:0];
        end
        r.coil  = COIL_SEQ[{model_phase, 2'b00} +: 4];
        r.phase = model_phase;
        r.dir   = model_ccw;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Drive tick words at the falling edge; hold a word until it is taken
    always @(negedge clk)
    begin : drive_ticks
        button_word_t w;
        if (rst_n && (!in_valid || tick_taken))
        begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_ticks.pop_front();
                cw_button     <= w.cw;
                ccw_button    <= w.ccw;
                faster_button <= w.faster;
                slower_button <= w.slower;
                in_valid      <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, or hold off for a long stretch on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Sample at the rising edge: track writes, predict taken words, check results
    always @(posedge clk)
    begin : watch_ports
        motor_result_t want;
        motor_result_t got;
        if (!rst_n)
        begin
            reset_motor_model();
            tick_taken <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                apply_setting(cfg_index, cfg_data);
            tick_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_results.push_back(advance_motor({cw_button, ccw_button,
                                                          faster_button, slower_button}));
            if (out_valid && !out_stall)
            begin
                got = {coil_pattern, phase_index, direction, step_taken};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word expected none actual %h", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("coil_pattern", int'(want.coil), int'(got.coil));
                    check_field("phase_index", int'(want.phase), int'(got.phase));
                    check_field("direction", int'(want.dir), int'(got.dir));
                    check_field("step_taken", int'(want.stepped), int'(got.stepped));
                end
            end
        end
    end

    task automatic queue_word(input button_word_t w);
        pending_ticks.push_back(w);
        held_levels = w;
    endtask

    // Random button levels; each button flips with the given chance per tick
    task automatic queue_ticks(input int count, input int toggle_pct);
        button_word_t w;
        for (int n = 0; n < count; n++)
        begin
            w = held_levels;
            if ($urandom_range(99) < toggle_pct)
                w.cw = ~w.cw;
            if ($urandom_range(99) < toggle_pct)
                w.ccw = ~w.ccw;
            if ($urandom_range(99) < toggle_pct)
                w.faster = ~w.faster;
            if ($urandom_range(99) < toggle_pct)
                w.slower = ~w.slower;
            queue_word(w);
        end
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 74; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 74; end
            IDLE_BOTH:     begin send_idle_pct = 24; stall_pct = 24; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Wait until every word is sent and every result has come back
    task automatic drain();
        @(posedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hss_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= hss_pkg::DW'(value);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_speed(input int floor_v, input int ceil_v, input int frac_v,
                             input int off_v);
        write_reg(hss_pkg::REG_DELAY_FLOOR, floor_v);
        write_reg(hss_pkg::REG_DELAY_CEIL, ceil_v);
        write_reg(hss_pkg::REG_CHANGE_FRACTION, frac_v);
        write_reg(hss_pkg::REG_CHANGE_OFFSET, off_v);
        end_writes();
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: levels held from reset, each edge alone and in pairs
        set_idling(IDLE_NONE);
        queue_word(button_word_t'(4'b1111));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b1000));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0100));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b1100));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0010));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0001));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0011));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b1111));
        queue_word(button_word_t'(4'b1111));
        queue_word(button_word_t'(4'b0000));
        queue_ticks(150, 30);
        drain();

        // Widest fraction and offset, written with spare upper bits set;
        // start delay and unused indexes must change nothing
        write_reg(hss_pkg::REG_DELAY_FLOOR, 0);
        write_reg(hss_pkg::REG_DELAY_CEIL, 4096);
        write_reg(hss_pkg::REG_START_DELAY, DELAY_TOP);
        write_reg(hss_pkg::REG_CHANGE_FRACTION, DELAY_TOP);
        write_reg(hss_pkg::REG_CHANGE_OFFSET, DELAY_TOP);
        for (int k = int'(hss_pkg::REG_CHANGE_OFFSET) + 1; k < (1 << hss_pkg::CFG_IDX_W); k++)
            write_reg(hss_pkg::CFG_IDX_W'(k), int'($urandom_range(0, DELAY_TOP)));
        end_writes();
        // delay drops to zero: step every tick, then run backwards through phase 0
        queue_word(button_word_t'(4'b0010));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0100));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0000));
        queue_ticks(260, 10);
        // long hold-off on the result side so the block backs up its input
        hold_requests++;
        drain();

        // No change per press, floor equal to ceiling
        set_idling(IDLE_SENDER);
        set_speed(1024, 1024, 0, 0);
        queue_ticks(200, 15);
        drain();

        // Floor above ceiling
        set_idling(IDLE_RECEIVER);
        set_speed(3000, 1000, int'($urandom_range(0, 255)), int'($urandom_range(0, 512)));
        queue_ticks(200, 15);
        drain();

        // Random settings with short delays, every idling mode in turn
        for (int k = 0; k < 4; k++)
        begin
            set_idling(idle_mode_t'(k));
            set_speed(int'($urandom_range(0, 2048)), int'($urandom_range(256, 6000)),
                      int'($urandom_range(0, 255)), int'($urandom_range(0, 2048)));
            queue_ticks(150, 20);
            drain();
        end

        // Clamps at the far ends, crossed
        set_idling(IDLE_BOTH);
        set_speed(DELAY_TOP, 0, int'($urandom_range(0, 255)),
                  int'($urandom_range(0, 65535)));
        queue_ticks(100, 20);
        drain();

        // Push the delay to saturation, then run quiet ticks far below a step
        set_idling(IDLE_NONE);
        set_speed(0, DELAY_TOP, 255, 65535);
        for (int k = 0; k < 10; k++)
        begin
            queue_word(button_word_t'(4'b0001));
            queue_word(button_word_t'(4'b0000));
        end
        for (int k = 0; k < SLOW_TICKS; k++)
            queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0010));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0000));
        queue_word(button_word_t'(4'b0000));
        drain();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
